// File: hdl/seqwt_pkg.sv
// seqwt_pkg: shared types and constants of the sequence number wakeup table
// no dependencies; used by seqno_wakeup_table and seqwt_older

package seqwt_pkg;

  // field widths fixed by the request and result formats
  localparam int SEQ_W      = 32;
  localparam int HALF_W     = 16;
  localparam int WAITER_FW  = 4;
  localparam int QUEUE_FW   = 2;
  localparam int COUNT_W    = 5;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

  // default table sizes
  localparam int DEF_NUM_WAITERS = 16;
  localparam int DEF_NUM_QUEUES  = 4;

  // command codes
  localparam logic CMD_REQUEST  = 1'b0;
  localparam logic CMD_PROGRESS = 1'b1;

  // result kind codes
  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_WAKE  = 1'b1;

  // reply status codes
  localparam logic STATUS_ARMED  = 1'b0;
  localparam logic STATUS_PASSED = 1'b1;

  typedef struct packed {
    logic                 command;
    logic [QUEUE_FW-1:0]  queue;
    logic [WAITER_FW-1:0] waiter;
    logic [HALF_W-1:0]    superbuf_seq;
    logic [HALF_W-1:0]    packet_index;
    logic                 allow_immediate;
  } request_t;

  typedef struct packed {
    logic                 kind;
    logic                 status;
    logic [WAITER_FW-1:0] woken_waiter;
    logic                 wake_valid;
    logic                 last;
  } result_t;

endpackage

// File: hdl/seqno_wakeup_table.sv
// seqno_wakeup_table: top level, sequencer over the waiter ram and compare unit
// depends on seqwt_pkg, seqwt_ram, seqwt_older
//
// Usage:
//   A request is taken at a rising edge with start high and busy low. A
//   wakeup request (command 0) gets exactly one reply result; a progress
//   event (command 1) gets one wake result per waiter it wakes, possibly none.
//   Each result is shown on result for one cycle with result_valid high; the
//   receiver cannot stall, so results are never held. The final result of a
//   request has last set.
//   A wakeup request holds busy only in the request state and its reply is
//   on result in the next cycle; a new request or event is taken only once
//   busy is low again. An event whose queue has no armed waiters holds busy
//   only in the event state. Otherwise the event scans every slot, one per
//   cycle through the single ram read port and the shared compare unit:
//   busy is held through the event, scan and flush states, and each wake is
//   held until the next is found or the scan ends, the final one coming on
//   result after the flush state.
//   Reset clears queue positions, armed flags and armed counts; waiter
//   targets are not cleared since a slot is only used once armed.

module seqno_wakeup_table #(
  parameter int NUM_WAITERS = seqwt_pkg::DEF_NUM_WAITERS,
  parameter int NUM_QUEUES  = seqwt_pkg::DEF_NUM_QUEUES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  seqwt_pkg::request_t request,
  output seqwt_pkg::result_t  result,
  output logic                result_valid
);

  localparam int WW    = (NUM_WAITERS > 1) ? $clog2(NUM_WAITERS) : 1;
  localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int RAM_W = seqwt_pkg::SEQ_W + QW;
  localparam logic [WW-1:0] LAST_SLOT = WW'(NUM_WAITERS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_REQ   = 3'd1;
  localparam logic [2:0] S_EVT   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic [2:0]                   state, state_next;
  seqwt_pkg::request_t          req, req_next;
  logic [seqwt_pkg::SEQ_W-1:0]  pos [NUM_QUEUES];
  logic [seqwt_pkg::SEQ_W-1:0]  pos_next [NUM_QUEUES];
  logic [seqwt_pkg::COUNT_W-1:0] cnt [NUM_QUEUES];
  logic [seqwt_pkg::COUNT_W-1:0] cnt_next [NUM_QUEUES];
  logic [NUM_WAITERS-1:0]       armed, armed_next;
  logic [WW-1:0]                scan_idx, scan_idx_next;
  logic [WW-1:0]                pend, pend_next;
  logic                         pend_valid, pend_valid_next;
  seqwt_pkg::result_t           result_next;
  logic                         result_valid_next;

  logic [seqwt_pkg::SEQ_W-1:0]  seq;
  logic [QW-1:0]                q_idx;
  logic [WW-1:0]                w_idx;
  logic                         q_ok, w_ok;
  logic                         ram_we;
  logic [WW-1:0]                ram_addr;
  logic [RAM_W-1:0]             ram_wdata, ram_rdata;
  logic [seqwt_pkg::SEQ_W-1:0]  rd_target;
  logic [QW-1:0]                rd_home;
  logic [seqwt_pkg::SEQ_W-1:0]  cmp_a, cmp_b;
  logic                         is_older;
  logic                         hit;

  // waiter target and home queue store
  seqwt_ram #(
    .WIDTH (RAM_W),
    .DEPTH (NUM_WAITERS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // shared sequence compare
  seqwt_older u_older (
    .a     (cmp_a),
    .b     (cmp_b),
    .older (is_older)
  );

  // decoded fields of the held request
  assign seq       = {req.superbuf_seq, req.packet_index};
  assign q_idx     = QW'(req.queue);
  assign w_idx     = WW'(req.waiter);
  assign q_ok      = 32'(req.queue) < 32'(NUM_QUEUES);
  assign w_ok      = 32'(req.waiter) < 32'(NUM_WAITERS);
  assign rd_target = ram_rdata[seqwt_pkg::SEQ_W-1:0];
  assign rd_home   = ram_rdata[seqwt_pkg::SEQ_W +: QW];
  assign ram_wdata = {q_idx, seq};
  assign busy      = (state != S_IDLE);
  assign hit       = armed[scan_idx] && (rd_home == q_idx) && is_older;

  // sequencer
  always_comb begin
    state_next        = state;
    req_next          = req;
    pos_next          = pos;
    cnt_next          = cnt;
    armed_next        = armed;
    scan_idx_next     = scan_idx;
    pend_next         = pend;
    pend_valid_next   = pend_valid;
    result_next       = result;
    result_valid_next = 1'b0;
    ram_we            = 1'b0;
    ram_addr          = WW'(request.waiter);
    cmp_a             = seq;
    cmp_b             = pos[q_idx];

    case (state)
      S_IDLE: begin
        if (start) begin
          req_next   = request;
          state_next = (request.command == seqwt_pkg::CMD_REQUEST) ? S_REQ : S_EVT;
        end
      end

      // request: ram already holds this waiter's slot
      S_REQ: begin
        ram_addr                 = w_idx;
        result_valid_next        = 1'b1;
        result_next.kind         = seqwt_pkg::KIND_REPLY;
        result_next.last         = 1'b1;
        result_next.status       = seqwt_pkg::STATUS_PASSED;
        result_next.wake_valid   = 1'b0;
        result_next.woken_waiter = '0;
        if (q_ok && w_ok) begin
          if (is_older) begin
            result_next.wake_valid = req.allow_immediate;
            if (req.allow_immediate) begin
              result_next.woken_waiter = req.waiter;
            end
          end else begin
            ram_we             = 1'b1;
            armed_next[w_idx]  = 1'b1;
            result_next.status = seqwt_pkg::STATUS_ARMED;
            // move the count when the waiter changes queue or is new
            for (int j = 0; j < NUM_QUEUES; j++) begin
              if (armed[w_idx] && (rd_home != q_idx) && (QW'(j) == rd_home) &&
                  (cnt[j] != '0)) begin
                cnt_next[j] = cnt[j] - 1'b1;
              end
              if ((!armed[w_idx] || (rd_home != q_idx)) && (QW'(j) == q_idx) &&
                  (cnt[j] != seqwt_pkg::COUNT_MAX)) begin
                cnt_next[j] = cnt[j] + 1'b1;
              end
            end
          end
        end
        state_next = S_IDLE;
      end

      // event: set position, start the scan if anyone is armed here
      S_EVT: begin
        ram_addr   = '0;
        state_next = S_IDLE;
        if (q_ok) begin
          pos_next[q_idx] = seq;
          if (cnt[q_idx] != '0) begin
            state_next      = S_SCAN;
            scan_idx_next   = '0;
            pend_valid_next = 1'b0;
          end
        end
      end

      // one slot per cycle, a wake is held back until the next is known
      S_SCAN: begin
        cmp_a    = rd_target;
        cmp_b    = seq;
        ram_addr = (scan_idx == LAST_SLOT) ? '0 : WW'(scan_idx + 1'b1);
        if (hit) begin
          armed_next[scan_idx] = 1'b0;
          if (cnt[q_idx] != '0) begin
            cnt_next[q_idx] = cnt[q_idx] - 1'b1;
          end
          if (pend_valid) begin
            result_valid_next        = 1'b1;
            result_next.kind         = seqwt_pkg::KIND_WAKE;
            result_next.status       = seqwt_pkg::STATUS_ARMED;
            result_next.woken_waiter = seqwt_pkg::WAITER_FW'(pend);
            result_next.wake_valid   = 1'b1;
            result_next.last         = 1'b0;
          end
          pend_next       = scan_idx;
          pend_valid_next = 1'b1;
        end
        if (scan_idx == LAST_SLOT) begin
          state_next = S_FLUSH;
        end else begin
          scan_idx_next = WW'(scan_idx + 1'b1);
        end
      end

      // final wake of the event
      S_FLUSH: begin
        if (pend_valid) begin
          result_valid_next        = 1'b1;
          result_next.kind         = seqwt_pkg::KIND_WAKE;
          result_next.status       = seqwt_pkg::STATUS_ARMED;
          result_next.woken_waiter = seqwt_pkg::WAITER_FW'(pend);
          result_next.wake_valid   = 1'b1;
          result_next.last         = 1'b1;
        end
        pend_valid_next = 1'b0;
        state_next      = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      armed        <= '0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
      for (int j = 0; j < NUM_QUEUES; j++) begin
        pos[j] <= '0;
        cnt[j] <= '0;
      end
    end else begin
      state        <= state_next;
      armed        <= armed_next;
      pend_valid   <= pend_valid_next;
      result_valid <= result_valid_next;
      pos          <= pos_next;
      cnt          <= cnt_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req      <= req_next;
    scan_idx <= scan_idx_next;
    pend     <= pend_next;
    result   <= result_next;
  end

endmodule

// File: hdl/seqwt_ram.sv
// seqwt_ram: generic single port ram with registered read
// no dependencies

module seqwt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read, read-first
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: hdl/seqwt_older.sv
// seqwt_older: shared wrapping sequence compare, a is older than b
// depends on seqwt_pkg

module seqwt_older (
  input  logic [seqwt_pkg::SEQ_W-1:0] a,
  input  logic [seqwt_pkg::SEQ_W-1:0] b,
  output logic                        older
);

  logic [seqwt_pkg::SEQ_W-1:0] diff;

  // sign of the wrapping difference
  assign diff  = a - b;
  assign older = diff[seqwt_pkg::SEQ_W-1];

endmodule
